[hdl/text_statistics_counter_core_assert.svh]
// assertion macros shared by the text statistics counter modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef TEXT_STATISTICS_COUNTER_CORE_ASSERT_SVH
`define TEXT_STATISTICS_COUNTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define TSC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tsc assertion failed");
// checked at every edge, reset included
`define TSC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("tsc assertion failed");
`else
`define TSC_ASSERT(label, prop)
`define TSC_ASSERT_ALWAYS(label, prop)
`endif
`endif

[hdl/tsc_pkg.sv]
// types, byte class constants and classifier functions for the text statistics counter
// no dependencies
package tsc_pkg;

	localparam int unsigned OUT_W = 32;
	localparam int unsigned NUM_COUNTS = 5;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_EXCL    = 8'h21;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_INV_EXCL  = 8'hAD;
	localparam logic [7:0] CH_INV_QUEST = 8'hA8;
	localparam logic [7:0] CH_SHARP_S = 8'hE1;
	localparam logic [7:0] CH_UP_U    = 8'h55;
	localparam logic [7:0] CH_UP_E    = 8'h45;
	localparam logic [1:0] SAT_TWO    = 2'd2;

	typedef struct packed {
		logic       inside_word;
		logic [7:0] previous_letter;
		logic [1:0] letters_seen;
		logic [1:0] syllables_seen;
		logic       abbreviation_pending;
	} word_state_t;

	localparam word_state_t WORD_STATE_RESET = '{
		inside_word: 1'b0,
		previous_letter: 8'h00,
		letters_seen: 2'd0,
		syllables_seen: 2'd0,
		abbreviation_pending: 1'b1
	};

	typedef struct packed {
		logic chars;
		logic words;
		logic sentences;
		logic lines;
		logic mono;
	} count_inc_t;

	function automatic logic [7:0] up_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h61:8'h7A]}) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h80:8'h9A], [8'hA0:8'hA5],
			CH_SHARP_S});
	endfunction

	function automatic logic is_vowel(input logic [7:0] c);
		logic [7:0] u;
		u = up_case(c);
		return (u inside {8'h41, 8'h45, 8'h49, 8'h4F, 8'h55, 8'h59}) ||
			(c inside {[8'h81:8'h86], [8'h88:8'h9A]});
	endfunction

	function automatic logic is_mark(input logic [7:0] c);
		return (c inside {CH_DOT, CH_COLON, CH_EXCL, CH_QUEST, CH_INV_EXCL, CH_INV_QUEST});
	endfunction

endpackage

[hdl/tsc_step.sv]
// next word state and counter increments for one text byte
// depends on tsc_pkg
module tsc_step (
	input  logic [7:0]          text_byte,
	input  logic                start_of_text,
	input  tsc_pkg::word_state_t state_cur,
	output tsc_pkg::word_state_t state_nxt,
	output tsc_pkg::count_inc_t  inc
);
	import tsc_pkg::*;

	word_state_t st;
	logic letter, vowel, mark, first, hit, prev_cons;

	always_comb begin
		st        = start_of_text ? WORD_STATE_RESET : state_cur;
		letter    = is_letter(text_byte);
		vowel     = is_vowel(text_byte);
		mark      = is_mark(text_byte);
		prev_cons = is_letter(st.previous_letter) && !is_vowel(st.previous_letter);
		first     = (st.letters_seen == 2'd1);
		hit       = ((prev_cons || first) && vowel) ||
			(up_case(st.previous_letter) == CH_UP_U && up_case(text_byte) == CH_UP_E);
		state_nxt = st;
		inc       = '0;
		if (letter) begin
			inc.chars = 1'b1;
			state_nxt.previous_letter = text_byte;
			if (!st.inside_word) begin
				state_nxt.inside_word    = 1'b1;
				state_nxt.letters_seen   = 2'd1;
				state_nxt.syllables_seen = {1'b0, vowel};
			end else begin
				if (hit && st.syllables_seen < SAT_TWO) begin
					state_nxt.syllables_seen = st.syllables_seen + 2'd1;
				end
				if (st.letters_seen < SAT_TWO) begin
					state_nxt.letters_seen = st.letters_seen + 2'd1;
				end
			end
		end else begin
			state_nxt.inside_word = 1'b0;
			if (st.inside_word) begin
				// a longer word right before a sentence mark clears the abbreviation flag instead
				if (mark && st.letters_seen >= SAT_TWO) begin
					state_nxt.abbreviation_pending = 1'b0;
				end else begin
					inc.words = 1'b1;
					inc.mono  = (st.syllables_seen <= 2'd1);
				end
			end
			if (mark) begin
				if (state_nxt.abbreviation_pending) begin
					state_nxt.abbreviation_pending = 1'b0;
				end else begin
					inc.sentences = 1'b1;
				end
			end
			if (text_byte == CH_NEWLINE) begin
				inc.lines = 1'b1;
			end else begin
				inc.chars = 1'b1;
			end
		end
	end

endmodule

[hdl/tsc_out_skid.sv]
// output register with one skid entry, so the input side keeps a registered ready
// depends on the assertion header
`include "text_statistics_counter_core_assert.svh"
module tsc_out_skid #(
	parameter int unsigned DATA_W = 160
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic [DATA_W-1:0] s_data,
	output logic              m_valid,
	input  logic              m_ready,
	output logic [DATA_W-1:0] m_data
);

	logic              main_valid_q, skid_valid_q;
	logic [DATA_W-1:0] main_q, skid_q;

	assign s_ready = !skid_valid_q;
	assign m_valid = main_valid_q;
	assign m_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_ready || !main_valid_q) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= s_valid;
			end
		end else if (s_valid && s_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_ready || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : s_data;
		end else if (s_valid && s_ready) begin
			skid_q <= s_data;
		end
	end

	`TSC_ASSERT_ALWAYS(a_skid_needs_main, skid_valid_q |-> main_valid_q)
	`TSC_ASSERT(a_skid_drains, (skid_valid_q && m_ready) |=> (main_valid_q && !skid_valid_q))
	`TSC_ASSERT(a_accept_shows, (s_valid && s_ready) |=> main_valid_q)
	`TSC_ASSERT(a_skid_holds, (skid_valid_q && !m_ready) |=> (skid_valid_q && $stable(skid_q)))

endmodule

[hdl/text_statistics_counter_core.sv]
// top level of the text statistics counter: byte classification, word state and counters
// depends on tsc_pkg, tsc_step and tsc_out_skid
// Takes one text byte per cycle and returns, for every byte, the running counts of
// characters (newlines excluded), words, sentences, lines and one-syllable words. A byte is
// taken in every cycle in which s_tvalid is high and the output side is not backed up; its
// counts are registered in the output stage before they show on m_tdata. Each byte is handled
// in a single pass of classifier compares and counter increments ahead of the count registers,
// and the result sits in a two-entry output stage; s_tready drops only after two results wait.
// s_tuser high clears all counts and word state before that byte. A word still open at the
// end of the text is not counted. Counters are COUNT_WIDTH bits, wrap, and show their low
// 32 bits (zero-extended when narrower).
module text_statistics_counter_core #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] text_byte
	input  logic         s_tuser,   // [0] start_of_text
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata    // char_count, word_count, sentence_count, line_count,
	                                // mono_count, 32 bits each from bit 0 up
);
	import tsc_pkg::*;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	word_state_t state_q, state_nxt;
	count_inc_t  inc;
	cnt_t        cnt_q [NUM_COUNTS];
	cnt_t        cnt_nxt [NUM_COUNTS];
	logic [NUM_COUNTS-1:0] inc_vec;
	logic [NUM_COUNTS*OUT_W-1:0] result;
	logic        accept;

	assign accept = s_tvalid && s_tready;

	tsc_step u_step (
		.text_byte     (s_tdata),
		.start_of_text (s_tuser),
		.state_cur     (state_q),
		.state_nxt     (state_nxt),
		.inc           (inc)
	);

	// lowest index is char_count
	assign inc_vec = {inc.mono, inc.lines, inc.sentences, inc.words, inc.chars};

	always_comb begin
		logic [COUNT_WIDTH+OUT_W-1:0] ext;
		for (int i = 0; i < NUM_COUNTS; i++) begin
			cnt_nxt[i] = (s_tuser ? cnt_t'(0) : cnt_q[i]) + cnt_t'(inc_vec[i]);
			ext = {{OUT_W{1'b0}}, cnt_nxt[i]};
			result[i*OUT_W +: OUT_W] = ext[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WORD_STATE_RESET;
			for (int i = 0; i < NUM_COUNTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			state_q <= state_nxt;
			for (int i = 0; i < NUM_COUNTS; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	tsc_out_skid #(
		.DATA_W (NUM_COUNTS*OUT_W)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.s_data  (result),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_data  (m_tdata)
	);

endmodule
